@@ rtl/core/text_command_frame_parser_unit_assert.svh @@
// Assertion macros shared by the text command frame parser RTL.
// Each macro expands to one labeled concurrent assertion clocked on the rising edge of the given clock.
`ifndef TEXT_COMMAND_FRAME_PARSER_UNIT_ASSERT_SVH
`define TEXT_COMMAND_FRAME_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define TFP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is low
`define TFP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/tfp_pkg.sv @@
// Shared constants, types and packing helper for the text command frame parser.
// No dependencies.
package tfp_pkg;

	// Frame characters
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_POUND = 8'h23;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	// Result kinds
	localparam logic [1:0] KIND_HDR = 2'd0;
	localparam logic [1:0] KIND_CMD = 2'd1;
	localparam logic [1:0] KIND_VAL = 2'd2;

	localparam int DATA_W = 48;

	// Frame summary handed from the parser to the drain logic
	typedef struct packed {
		logic        ok;
		logic        has_address;
		logic [15:0] address;
	} tfp_frame_t;

	// Pack result fields into the output data word, lowest field first
	function automatic logic [DATA_W-1:0] pack_data(
		input logic        ok,
		input logic        has_address,
		input logic [15:0] address,
		input logic [4:0]  command_length,
		input logic [3:0]  value_count,
		input logic [15:0] payload
	);
		return {5'd0, payload, value_count, command_length, address, has_address, ok};
	endfunction

endpackage

@@ rtl/core/tfp_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/tfp_parse.sv @@
// Per-byte frame parser: tracks frame phase, address and field accumulators.
// Issues command and value writes to the stores; uses tfp_pkg.
module tfp_parse #(
	parameter int MAX_FRAME  = 64,
	parameter int CMD_MAX    = 16,
	parameter int MAX_VALUES = 8,
	localparam int CAW = (CMD_MAX > 1) ? $clog2(CMD_MAX) : 1,
	localparam int VAW = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1,
	localparam int CCW = $clog2(CMD_MAX + 1),
	localparam int VCW = $clog2(MAX_VALUES + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,        // non-terminator byte transfer
	input  logic                frame_end,   // terminator byte transfer
	input  logic [7:0]          in_byte,
	output logic                cmd_we,
	output logic [CAW-1:0]      cmd_waddr,
	output logic [7:0]          cmd_wdata,
	output logic                val_we,
	output logic [VAW-1:0]      val_waddr,
	output logic [15:0]         val_wdata,
	output tfp_pkg::tfp_frame_t frame,
	output logic [CCW-1:0]      cmd_count,
	output logic [VCW-1:0]      val_count
);

	import tfp_pkg::*;

	localparam int BCW = $clog2(MAX_FRAME);

	localparam logic [1:0] PH_PRE     = 2'd0;
	localparam logic [1:0] PH_CMD     = 2'd1;
	localparam logic [1:0] PH_CONTENT = 2'd2;

	logic [1:0]     phase_q, phase_n;
	logic           bad_q, bad_n;
	logic           pound_q, pound_n;
	logic [15:0]    aacc_q, aacc_n;
	logic           adone_q, adone_n;
	logic           astart_q, astart_n;
	logic           aneg_q, aneg_n;
	logic [CCW-1:0] ccnt_q, ccnt_n;
	logic [VCW-1:0] vidx_q, vidx_n;
	logic [15:0]    facc_q, facc_n;
	logic           fany_q, fany_n;
	logic           fneg_q, fneg_n;
	logic [BCW-1:0] bcnt_q, bcnt_n;

	logic           is_digit;
	logic           is_ws;
	logic [15:0]    digit_val;
	logic [15:0]    field_val;
	logic [BCW:0]   bcnt_inc;

	assign is_digit  = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
	assign is_ws     = (in_byte == CH_SPACE) || ((in_byte >= CH_TAB) && (in_byte <= CH_CR));
	assign digit_val = {8'd0, in_byte - CH_ZERO};
	assign field_val = fneg_q ? (16'd0 - facc_q) : facc_q;
	assign bcnt_inc  = {1'b0, bcnt_q} + (BCW + 1)'(1);

	assign cmd_waddr = ccnt_q[CAW-1:0];
	assign cmd_wdata = in_byte;
	assign val_waddr = vidx_q[VAW-1:0];
	assign val_wdata = field_val;

	// Next-state logic for one byte
	always_comb begin
		phase_n  = phase_q;
		bad_n    = bad_q;
		pound_n  = pound_q;
		aacc_n   = aacc_q;
		adone_n  = adone_q;
		astart_n = astart_q;
		aneg_n   = aneg_q;
		ccnt_n   = ccnt_q;
		vidx_n   = vidx_q;
		facc_n   = facc_q;
		fany_n   = fany_q;
		fneg_n   = fneg_q;
		bcnt_n   = bcnt_q;
		cmd_we   = 1'b0;
		val_we   = 1'b0;

		if (step) begin
			if (!bad_q) begin
				case (phase_q)
					PH_PRE: begin
						if ((in_byte == CH_GT) || (in_byte == CH_COMMA)) begin
							bad_n = 1'b1;
						end else if (in_byte == CH_LT) begin
							phase_n = PH_CMD;
						end else if ((in_byte == CH_POUND) && !pound_q) begin
							pound_n = 1'b1;
						end else if (pound_q && !adone_q) begin
							// skip leading blanks, take one sign, then digits
							if (!astart_q && is_ws) begin
								astart_n = 1'b0;
							end else if (!astart_q && (in_byte == CH_MINUS)) begin
								astart_n = 1'b1;
								aneg_n   = 1'b1;
							end else if (!astart_q && (in_byte == CH_PLUS)) begin
								astart_n = 1'b1;
							end else begin
								astart_n = 1'b1;
								if (is_digit) begin
									aacc_n = (aacc_q << 3) + (aacc_q << 1) + digit_val;
								end else begin
									adone_n = 1'b1;
								end
							end
						end
					end
					PH_CMD: begin
						if (in_byte == CH_GT) begin
							phase_n = PH_CONTENT;
						end else if ((in_byte == CH_COMMA) ||
							((in_byte == CH_POUND) && !pound_q)) begin
							bad_n = 1'b1;
						end else if (ccnt_q < CCW'(CMD_MAX)) begin
							cmd_we = 1'b1;
							ccnt_n = ccnt_q + CCW'(1);
						end else begin
							bad_n = 1'b1;
						end
					end
					default: begin
						if (in_byte == CH_COMMA) begin
							if (!fany_q) begin
								bad_n = 1'b1;
							end else begin
								if (vidx_q < VCW'(MAX_VALUES)) begin
									val_we = 1'b1;
									vidx_n = vidx_q + VCW'(1);
								end else begin
									bad_n = 1'b1;
								end
								facc_n = 16'd0;
								fany_n = 1'b0;
								fneg_n = 1'b0;
							end
						end else if ((in_byte == CH_MINUS) && !fany_q) begin
							fneg_n = 1'b1;
							fany_n = 1'b1;
						end else if (is_digit) begin
							facc_n = (facc_q << 3) + (facc_q << 1) + digit_val;
							fany_n = 1'b1;
						end else begin
							bad_n = 1'b1;
						end
					end
				endcase
			end
			bcnt_n = bcnt_inc[BCW-1:0];
		end

		// Close the last field at the terminator
		if (frame_end) begin
			if (!bad_q && (phase_q == PH_CONTENT)) begin
				if (!((vidx_q == '0) && !fany_q)) begin
					if (!fany_q) begin
						bad_n = 1'b1;
					end else if (vidx_q < VCW'(MAX_VALUES)) begin
						val_we = 1'b1;
						vidx_n = vidx_q + VCW'(1);
					end else begin
						bad_n = 1'b1;
					end
				end
			end else begin
				bad_n = 1'b1;
			end
		end
	end

	// Frame summary at the terminator
	assign frame.ok          = !bad_n;
	assign frame.has_address = !bad_n && pound_q;
	assign frame.address     = (!bad_n && pound_q) ?
		(aneg_q ? (16'd0 - aacc_q) : aacc_q) : 16'd0;
	assign cmd_count         = ccnt_q;
	assign val_count         = vidx_n;

	// Hold frame state; drop it at the terminator or at the buffer limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_PRE;
			bad_q    <= 1'b0;
			pound_q  <= 1'b0;
			aacc_q   <= 16'd0;
			adone_q  <= 1'b0;
			astart_q <= 1'b0;
			aneg_q   <= 1'b0;
			ccnt_q   <= '0;
			vidx_q   <= '0;
			facc_q   <= 16'd0;
			fany_q   <= 1'b0;
			fneg_q   <= 1'b0;
			bcnt_q   <= '0;
		end else if (frame_end || (step && (bcnt_inc == (BCW + 1)'(MAX_FRAME)))) begin
			phase_q  <= PH_PRE;
			bad_q    <= 1'b0;
			pound_q  <= 1'b0;
			aacc_q   <= 16'd0;
			adone_q  <= 1'b0;
			astart_q <= 1'b0;
			aneg_q   <= 1'b0;
			ccnt_q   <= '0;
			vidx_q   <= '0;
			facc_q   <= 16'd0;
			fany_q   <= 1'b0;
			fneg_q   <= 1'b0;
			bcnt_q   <= '0;
		end else begin
			phase_q  <= phase_n;
			bad_q    <= bad_n;
			pound_q  <= pound_n;
			aacc_q   <= aacc_n;
			adone_q  <= adone_n;
			astart_q <= astart_n;
			aneg_q   <= aneg_n;
			ccnt_q   <= ccnt_n;
			vidx_q   <= vidx_n;
			facc_q   <= facc_n;
			fany_q   <= fany_n;
			fneg_q   <= fneg_n;
			bcnt_q   <= bcnt_n;
		end
	end

endmodule

@@ rtl/core/text_command_frame_parser_unit.sv @@
// A byte other than ';' is absorbed on its transfer; s_tready is high while idle.
// At ';' the sequencer enters the header state, which loads the header into the output register
// once the output slot is free; each command byte and value then passes through a store read
// state and an output load state. s_tready stays low until the frame's last result is loaded.
// arst_n clears all control state at once; the stores are not cleared.
module text_command_frame_parser_unit #(
	parameter int MAX_FRAME  = 64,
	parameter int CMD_MAX    = 16,
	parameter int MAX_VALUES = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,   // [7:0] in_byte
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [tfp_pkg::DATA_W-1:0]  m_tdata,   // [0] frame_ok, [1] has_address,
	                                               // [17:2] address, [22:18] command_length,
	                                               // [26:23] value_count, [42:27] payload
	output logic [1:0]                  m_tuser,   // [1:0] kind
	output logic                        m_tlast
);

	import tfp_pkg::*;

	`include "text_command_frame_parser_unit_assert.svh"

	localparam int CAW = (CMD_MAX > 1) ? $clog2(CMD_MAX) : 1;
	localparam int VAW = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
	localparam int CCW = $clog2(CMD_MAX + 1);
	localparam int VCW = $clog2(MAX_VALUES + 1);
	localparam int IW  = (CCW > VCW) ? CCW : VCW;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_HDR  = 3'd1;
	localparam logic [2:0] S_CRD  = 3'd2;
	localparam logic [2:0] S_CLD  = 3'd3;
	localparam logic [2:0] S_VRD  = 3'd4;
	localparam logic [2:0] S_VLD  = 3'd5;

	logic [2:0]        state_q, state_n;
	logic [IW-1:0]     rd_idx_q, rd_idx_n;
	logic [IW-1:0]     idx_inc;
	tfp_frame_t        hdr_q;
	logic [CCW-1:0]    ccnt_q;
	logic [VCW-1:0]    vcnt_q;

	logic              in_xfer;
	logic              is_semi;
	logic              slot_free;

	logic              cmd_we;
	logic [CAW-1:0]    cmd_waddr;
	logic [7:0]        cmd_wdata;
	logic [7:0]        cmd_rdata;
	logic              val_we;
	logic [VAW-1:0]    val_waddr;
	logic [15:0]       val_wdata;
	logic [15:0]       val_rdata;
	tfp_frame_t        frame;
	logic [CCW-1:0]    frame_ccnt;
	logic [VCW-1:0]    frame_vcnt;

	logic              out_valid_q;
	logic [DATA_W-1:0] out_data_q;
	logic [1:0]        out_user_q;
	logic              out_last_q;
	logic              ld;
	logic [DATA_W-1:0] ld_data;
	logic [1:0]        ld_user;
	logic              ld_last;

	assign s_tready  = (state_q == S_IDLE);
	assign in_xfer   = s_tvalid && s_tready;
	assign is_semi   = (s_tdata == CH_SEMI);
	assign slot_free = !out_valid_q || m_tready;
	assign idx_inc   = rd_idx_q + IW'(1);

	tfp_parse #(
		.MAX_FRAME  (MAX_FRAME),
		.CMD_MAX    (CMD_MAX),
		.MAX_VALUES (MAX_VALUES)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (in_xfer && !is_semi),
		.frame_end (in_xfer && is_semi),
		.in_byte   (s_tdata),
		.cmd_we    (cmd_we),
		.cmd_waddr (cmd_waddr),
		.cmd_wdata (cmd_wdata),
		.val_we    (val_we),
		.val_waddr (val_waddr),
		.val_wdata (val_wdata),
		.frame     (frame),
		.cmd_count (frame_ccnt),
		.val_count (frame_vcnt)
	);

	tfp_ram #(
		.WIDTH (8),
		.DEPTH (CMD_MAX)
	) u_cmd_ram (
		.clk   (clk),
		.we    (cmd_we),
		.waddr (cmd_waddr),
		.wdata (cmd_wdata),
		.raddr (rd_idx_q[CAW-1:0]),
		.rdata (cmd_rdata)
	);

	tfp_ram #(
		.WIDTH (16),
		.DEPTH (MAX_VALUES)
	) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (val_waddr),
		.wdata (val_wdata),
		.raddr (rd_idx_q[VAW-1:0]),
		.rdata (val_rdata)
	);

	// Drain sequencer: header, then command bytes, then values (a failed frame sends the header only)
	always_comb begin
		state_n  = state_q;
		rd_idx_n = rd_idx_q;
		ld       = 1'b0;
		ld_data  = '0;
		ld_user  = KIND_HDR;
		ld_last  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_xfer && is_semi) begin
					state_n = S_HDR;
				end
			end
			S_HDR: begin
				if (slot_free) begin
					ld       = 1'b1;
					rd_idx_n = '0;
					if (!hdr_q.ok) begin
						ld_last = 1'b1;
						state_n = S_IDLE;
					end else begin
						ld_data = pack_data(1'b1, hdr_q.has_address, hdr_q.address,
							5'(ccnt_q), 4'(vcnt_q), 16'd0);
						ld_last = (ccnt_q == '0) && (vcnt_q == '0);
						if (ccnt_q != '0) begin
							state_n = S_CRD;
						end else if (vcnt_q != '0) begin
							state_n = S_VRD;
						end else begin
							state_n = S_IDLE;
						end
					end
				end
			end
			S_CRD: begin
				state_n = S_CLD;
			end
			S_CLD: begin
				if (slot_free) begin
					ld      = 1'b1;
					ld_user = KIND_CMD;
					ld_data = pack_data(1'b0, 1'b0, 16'd0, 5'd0, 4'd0, {8'd0, cmd_rdata});
					if (idx_inc == IW'(ccnt_q)) begin
						ld_last  = (vcnt_q == '0);
						rd_idx_n = '0;
						state_n  = (vcnt_q != '0) ? S_VRD : S_IDLE;
					end else begin
						rd_idx_n = idx_inc;
						state_n  = S_CRD;
					end
				end
			end
			S_VRD: begin
				state_n = S_VLD;
			end
			S_VLD: begin
				if (slot_free) begin
					ld      = 1'b1;
					ld_user = KIND_VAL;
					ld_data = pack_data(1'b0, 1'b0, 16'd0, 5'd0, 4'd0, val_rdata);
					if (idx_inc == IW'(vcnt_q)) begin
						ld_last  = 1'b1;
						rd_idx_n = '0;
						state_n  = S_IDLE;
					end else begin
						rd_idx_n = idx_inc;
						state_n  = S_VRD;
					end
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rd_idx_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_n;
			rd_idx_q <= rd_idx_n;
			if (ld) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Capture the frame summary and load the output stage
	always_ff @(posedge clk) begin
		if (in_xfer && is_semi) begin
			hdr_q  <= frame;
			ccnt_q <= frame_ccnt;
			vcnt_q <= frame_vcnt;
		end
		if (ld) begin
			out_data_q <= ld_data;
			out_user_q <= ld_user;
			out_last_q <= ld_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;
	assign m_tlast  = out_last_q;

	`TFP_ASSERT_IMP(a_drain_blocks_input, clk, arst_n,
		m_tvalid && !m_tlast, !s_tready,
		"input open while a frame is still draining")
	`TFP_ASSERT_NXT(a_semi_starts_header, clk, arst_n,
		s_tvalid && s_tready && (s_tdata == CH_SEMI), state_q == S_HDR,
		"terminator did not start the header")
	`TFP_ASSERT_IMP(a_bad_header_is_last, clk, arst_n,
		m_tvalid && (m_tuser == KIND_HDR) && !m_tdata[0], m_tlast,
		"wrong-frame header not marked last")
	`TFP_ASSERT_IMP(a_counts_in_range, clk, arst_n,
		state_q != S_IDLE, (ccnt_q <= CCW'(CMD_MAX)) && (vcnt_q <= VCW'(MAX_VALUES)),
		"drain count beyond store depth")

endmodule

@@ tb/text_command_frame_parser_unit_test.sv @@
// Self-checking testbench for text_command_frame_parser_unit: directed frames, then random ones.
// Expected results come from a behavioral frame parser kept inside this file, or from the plan for typed rows.
// Depends on tfp_pkg and the parser RTL only.
module text_command_frame_parser_unit_test;
	import tfp_pkg::*;

	localparam int MAX_FRAME  = 64;
	localparam int CMD_MAX    = 16;
	localparam int MAX_VALUES = 8;
	localparam int IDLE_PCT   = 38;

	typedef enum logic [1:0] {PARSE_PREFIX, PARSE_COMMAND, PARSE_CONTENT} parse_phase_e;

	typedef struct packed {
		logic [1:0]  kind;
		logic        ok;
		logic        has_addr;
		logic [15:0] address;
		logic [4:0]  cmd_len;
		logic [3:0]  val_cnt;
		logic [15:0] payload;
		logic        last;
	} frame_result_t;

	typedef struct {
		int          filler;
		string       text;
		bit          typed;
		logic        ok;
		logic        has_addr;
		logic [15:0] address;
	} directed_row_t;

	// Directed frames; typed rows carry their single header, the rest use the parser model
	directed_row_t plan [0:23] = '{
		'{0,  "<>;",                                1, 1'b1, 1'b0, 16'h0000},
		'{0,  "#-32768<>;",                         1, 1'b1, 1'b1, 16'h8000},
		'{0,  "#65535<>;",                          1, 1'b1, 1'b1, 16'hFFFF},
		'{0,  "# \t+12x<AB>-1,65535,-;",            0, 1'b0, 1'b0, 16'h0000},
		'{0,  "junk#7<cmd>;",                       0, 1'b0, 1'b0, 16'h0000},
		'{0,  "<0123456789abcdef>1,2,3,4,5,6,7,8;", 0, 1'b0, 1'b0, 16'h0000},
		'{0,  "<0123456789abcdefg>;",               1, 1'b0, 1'b0, 16'h0000},
		'{0,  "<x>1,2,3,4,5,6,7,8,9;",              1, 1'b0, 1'b0, 16'h0000},
		'{0,  "<x>1,,2;",                           1, 1'b0, 1'b0, 16'h0000},
		'{0,  "<x>1,;",                             1, 1'b0, 1'b0, 16'h0000},
		'{0,  "<x>,;",                              1, 1'b0, 1'b0, 16'h0000},
		'{0,  ">x<y>;",                             1, 1'b0, 1'b0, 16'h0000},
		'{0,  "a,<y>;",                             1, 1'b0, 1'b0, 16'h0000},
		'{0,  "<a,b>;",                             1, 1'b0, 1'b0, 16'h0000},
		'{0,  "<a#b>1;",                            1, 1'b0, 1'b0, 16'h0000},
		'{0,  "#1<a#b>-0;",                         0, 1'b0, 1'b0, 16'h0000},
		'{0,  "<ab>1x;",                            1, 1'b0, 1'b0, 16'h0000},
		'{0,  "abc;",                               1, 1'b0, 1'b0, 16'h0000},
		'{0,  ";",                                  1, 1'b0, 1'b0, 16'h0000},
		'{0,  "<\377\001>99999,-99999;",            0, 1'b0, 1'b0, 16'h0000},
		'{0,  "#\r-\n5<q>7;",                       0, 1'b0, 1'b0, 16'h0000},
		'{64, "<k>5;",                              0, 1'b0, 1'b0, 16'h0000},
		'{59, "<k>1;",                              0, 1'b0, 1'b0, 16'h0000},
		'{62, "<k>;",                               0, 1'b0, 1'b0, 16'h0000}
	};

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [7:0]          s_tdata  = 8'h00;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [DATA_W-1:0]   m_tdata;
	logic [1:0]          m_tuser;
	logic                m_tlast;

	text_command_frame_parser_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #10 clk = ~clk;

	// Parser model state
	parse_phase_e phase;
	logic         frame_bad;
	logic         pound_seen;
	logic [15:0]  addr_accum;
	logic         addr_done;
	logic         addr_started;
	logic         addr_neg;
	logic [7:0]   cmd_store [CMD_MAX];
	logic [4:0]   cmd_count;
	logic [15:0]  value_store [MAX_VALUES];
	logic [3:0]   value_index;
	logic [15:0]  field_accum;
	logic [6:0]   field_chars;
	logic         field_neg;
	logic [6:0]   byte_count;

	frame_result_t awaited_results[$];
	frame_result_t fresh_results[$];
	logic [7:0]    frame_bytes[$];

	int mismatches      = 0;
	int bytes_accepted  = 0;
	int results_checked = 0;
	int directed_frames = 0;
	int random_frames   = 0;

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatches++;
	endtask

	function automatic bit is_digit(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic void clear_frame_state();
		phase        = PARSE_PREFIX;
		frame_bad    = 1'b0;
		pound_seen   = 1'b0;
		addr_accum   = '0;
		addr_done    = 1'b0;
		addr_started = 1'b0;
		addr_neg     = 1'b0;
		cmd_count    = '0;
		value_index  = '0;
		field_accum  = '0;
		field_chars  = '0;
		field_neg    = 1'b0;
		byte_count   = '0;
	endfunction

	// Skip white space, take one sign, then accumulate digits until the first other byte
	function automatic void take_address_char(input logic [7:0] c);
		if (addr_done)
			return;
		if (!addr_started) begin
			if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
				return;
			addr_started = 1'b1;
			if (c == CH_MINUS) begin
				addr_neg = 1'b1;
				return;
			end
			if (c == CH_PLUS)
				return;
		end
		if (is_digit(c))
			addr_accum = addr_accum * 16'd10 + 16'(c - CH_ZERO);
		else
			addr_done = 1'b1;
	endfunction

	function automatic void close_value();
		if (value_index < MAX_VALUES) begin
			value_store[value_index] = field_neg ? -field_accum : field_accum;
			value_index++;
		end else begin
			frame_bad = 1'b1;
		end
		field_accum = '0;
		field_chars = '0;
		field_neg   = 1'b0;
	endfunction

	function automatic void parse_char(input logic [7:0] c);
		case (phase)
			PARSE_PREFIX: begin
				if (c == CH_GT || c == CH_COMMA)
					frame_bad = 1'b1;
				else if (c == CH_LT)
					phase = PARSE_COMMAND;
				else if (c == CH_POUND && !pound_seen)
					pound_seen = 1'b1;
				else if (pound_seen)
					take_address_char(c);
			end
			PARSE_COMMAND: begin
				if (c == CH_GT)
					phase = PARSE_CONTENT;
				else if (c == CH_COMMA || (c == CH_POUND && !pound_seen))
					frame_bad = 1'b1;
				else if (cmd_count < CMD_MAX) begin
					cmd_store[cmd_count] = c;
					cmd_count++;
				end else
					frame_bad = 1'b1;
			end
			default: begin
				if (c == CH_COMMA) begin
					if (field_chars == 0)
						frame_bad = 1'b1;
					else
						close_value();
				end else if (c == CH_MINUS && field_chars == 0) begin
					field_neg   = 1'b1;
					field_chars = 7'd1;
				end else if (is_digit(c)) begin
					field_accum = field_accum * 16'd10 + 16'(c - CH_ZERO);
					if (field_chars < 7'd127)
						field_chars++;
				end else begin
					frame_bad = 1'b1;
				end
			end
		endcase
	endfunction

	// Advance the parser by one byte; a frame end leaves its results in fresh_results
	function automatic void parse_frame_byte(input logic [7:0] c);
		frame_result_t r;
		fresh_results = {};
		if (c != CH_SEMI) begin
			if (!frame_bad)
				parse_char(c);
			byte_count++;
			if (byte_count >= MAX_FRAME)
				clear_frame_state();
			return;
		end
		if (!frame_bad && phase == PARSE_CONTENT) begin
			if (!(value_index == 0 && field_chars == 0)) begin
				if (field_chars == 0)
					frame_bad = 1'b1;
				else
					close_value();
			end
		end else begin
			frame_bad = 1'b1;
		end
		r = '0;
		r.kind = KIND_HDR;
		if (!frame_bad) begin
			r.ok       = 1'b1;
			r.has_addr = pound_seen;
			r.address  = !pound_seen ? 16'h0000 : (addr_neg ? -addr_accum : addr_accum);
			r.cmd_len  = cmd_count;
			r.val_cnt  = value_index;
		end
		fresh_results.push_back(r);
		if (!frame_bad) begin
			for (int i = 0; i < cmd_count; i++) begin
				r         = '0;
				r.kind    = KIND_CMD;
				r.payload = {8'h00, cmd_store[i]};
				fresh_results.push_back(r);
			end
			for (int i = 0; i < value_index; i++) begin
				r         = '0;
				r.kind    = KIND_VAL;
				r.payload = value_store[i];
				fresh_results.push_back(r);
			end
		end
		fresh_results[fresh_results.size() - 1].last = 1'b1;
		clear_frame_state();
	endfunction

	function automatic bit source_steady();
		return bytes_accepted >= 420 && bytes_accepted < 520;
	endfunction

	function automatic bit sink_steady();
		return results_checked >= 80 && results_checked < 160;
	endfunction

	// Offer one byte, idling at random first; queue its predicted results on transfer unless typed
	task automatic send_byte(input logic [7:0] b, input bit typed);
		while (!source_steady() && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		bytes_accepted++;
		parse_frame_byte(b);
		if (!typed)
			foreach (fresh_results[i])
				awaited_results.push_back(fresh_results[i]);
	endtask

	function automatic logic [7:0] pick_letter();
		return 8'("a") + 8'($urandom_range(25));
	endfunction

	function automatic logic [7:0] pick_digit();
		return CH_ZERO + 8'($urandom_range(9));
	endfunction

	// Build one random frame into frame_bytes: mostly well formed, some noise or overlong
	task automatic compose_frame();
		int          style;
		int          n;
		int          digits;
		bit          neg;
		logic [7:0]  b;
		frame_bytes = {};
		style = $urandom_range(99);
		if (style < 10) begin
			repeat ($urandom_range(1, 12))
				frame_bytes.push_back(8'($urandom_range(255)));
		end else begin
			// Overlong filler may run past the buffer limit before the real frame starts
			if (style < 14)
				repeat ($urandom_range(55, 70))
					frame_bytes.push_back(pick_letter());
			if ($urandom_range(99) < 20)
				repeat ($urandom_range(1, 3))
					frame_bytes.push_back(pick_letter());
			if ($urandom_range(99) < 50) begin
				frame_bytes.push_back(CH_POUND);
				if ($urandom_range(99) < 25)
					frame_bytes.push_back($urandom_range(1) ? CH_SPACE :
						8'($urandom_range(CH_TAB, CH_CR)));
				n = $urandom_range(2);
				if (n == 1)
					frame_bytes.push_back(CH_PLUS);
				else if (n == 2)
					frame_bytes.push_back(CH_MINUS);
				repeat ($urandom_range(0, 6))
					frame_bytes.push_back(pick_digit());
				if ($urandom_range(99) < 20)
					frame_bytes.push_back(pick_letter());
			end
			frame_bytes.push_back(CH_LT);
			n = ($urandom_range(99) < 8) ? 17 : $urandom_range(0, 16);
			repeat (n) begin
				do
					b = 8'($urandom_range(255));
				while (b == CH_SEMI || b == CH_GT || b == CH_COMMA || b == CH_POUND);
				frame_bytes.push_back(b);
			end
			frame_bytes.push_back(CH_GT);
			n = ($urandom_range(99) < 8) ? 9 : $urandom_range(0, 8);
			for (int v = 0; v < n; v++) begin
				if (v != 0)
					frame_bytes.push_back(CH_COMMA);
				neg = $urandom_range(99) < 30;
				if (neg)
					frame_bytes.push_back(CH_MINUS);
				digits = $urandom_range(neg ? 0 : 1, 6);
				repeat (digits)
					frame_bytes.push_back(pick_digit());
			end
			// Break some frames with a stray byte
			if (frame_bytes.size() > 0 && $urandom_range(99) < 10)
				frame_bytes[$urandom_range(frame_bytes.size() - 1)] = 8'($urandom_range(255));
		end
		frame_bytes.push_back(CH_SEMI);
	endtask

	task automatic compare_field(input string name, input int got, input int want);
		if (got != want)
			report_mismatch($sformatf("result %0d %s is %0h, expected %0h",
				results_checked, name, got, want));
	endtask

	// Check each result transfer against the oldest expectation
	task automatic check_result();
		frame_result_t got;
		frame_result_t want;
		got.kind     = m_tuser;
		got.ok       = m_tdata[0];
		got.has_addr = m_tdata[1];
		got.address  = m_tdata[17:2];
		got.cmd_len  = m_tdata[22:18];
		got.val_cnt  = m_tdata[26:23];
		got.payload  = m_tdata[42:27];
		got.last     = m_tlast;
		if (awaited_results.size() == 0) begin
			report_mismatch($sformatf("result %0d arrived with none expected", results_checked));
		end else begin
			want = awaited_results.pop_front();
			compare_field("kind", got.kind, want.kind);
			compare_field("frame_ok", got.ok, want.ok);
			compare_field("has_address", got.has_addr, want.has_addr);
			compare_field("address", got.address, want.address);
			compare_field("command_length", got.cmd_len, want.cmd_len);
			compare_field("value_count", got.val_cnt, want.val_cnt);
			compare_field("payload", got.payload, want.payload);
			compare_field("last", got.last, want.last);
		end
		results_checked++;
	endtask

	// Take results and stall the output at random
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			check_result();
		m_tready <= sink_steady() || $urandom_range(99) >= IDLE_PCT;
	end

	initial begin
		frame_result_t typed_hdr;
		int            random_bytes;
		clear_frame_state();
		random_bytes = 0;
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames
		foreach (plan[i]) begin
			repeat (plan[i].filler)
				send_byte("z", plan[i].typed);
			for (int k = 0; k < plan[i].text.len(); k++)
				send_byte(plan[i].text[k], plan[i].typed);
			if (plan[i].typed) begin
				typed_hdr          = '0;
				typed_hdr.kind     = KIND_HDR;
				typed_hdr.ok       = plan[i].ok;
				typed_hdr.has_addr = plan[i].has_addr;
				typed_hdr.address  = plan[i].address;
				typed_hdr.last     = 1'b1;
				awaited_results.push_back(typed_hdr);
			end
			directed_frames++;
		end

		// Random frames
		while (random_bytes < 200) begin
			compose_frame();
			foreach (frame_bytes[i])
				send_byte(frame_bytes[i], 1'b0);
			random_bytes += frame_bytes.size();
			random_frames++;
		end
		s_tvalid <= 1'b0;

		// Drain, then leave room for any stray result
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (60)
			@(posedge clk);

		$display("Sent %0d directed and %0d random frames, %0d bytes in total.",
			directed_frames, random_frames, bytes_accepted);
		$display("Checked %0d results, %0d mismatches.", results_checked, mismatches);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Hard stop for a hung handshake
	initial begin
		#4000000;
		$display("Timed out with %0d results still expected.", awaited_results.size());
		$display("FAIL");
		$finish;
	end

endmodule
